>>> hdl/gbl_pkg.sv
// ----------------------------------------------------------------------------
// gbl_pkg
// Types, codes and default sizes shared by the gap buffer line editor files.
// ----------------------------------------------------------------------------
package gbl_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned COUNT_OUT_W  = 11;

  typedef enum logic [2:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_BACK   = 3'd2,
    OP_INSERT = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EDGE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [7:0]       char_in;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [7:0]             char_out;
    logic [COUNT_OUT_W-1:0] cursor;
    logic [COUNT_OUT_W-1:0] length;
  } out_word_t;

endpackage

>>> hdl/gbl_store.sv
// ----------------------------------------------------------------------------
// gbl_store
// Text store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module gbl_store #(
  parameter int unsigned DEPTH = gbl_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/gbl_ctrl.sv
// ----------------------------------------------------------------------------
// gbl_ctrl
// Command sequencer: holds the gap counts, issues the store read when a
// command is taken and does the write back and forms the registered result in the next cycle.
// ----------------------------------------------------------------------------
module gbl_ctrl #(
  parameter int unsigned CAPACITY = gbl_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gbl_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gbl_pkg::out_word_t out_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [7:0]        rd_data,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Working width: holds any count, any position and their sums.
  localparam int unsigned EW = ((CW > gbl_pkg::POS_W) ? CW : gbl_pkg::POS_W) + 1;
  localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

  gbl_pkg::state_t    state_r, state_nxt;
  gbl_pkg::in_word_t  cmd_r;
  logic [CW-1:0]      left_r, left_nxt;
  logic [CW-1:0]      right_r, right_nxt;
  logic               out_valid_r, out_valid_nxt;
  gbl_pkg::out_word_t out_data_r, out_data_nxt;

  logic               accept;
  logic [EW-1:0]      left_e, right_e, total_e, pos_e, in_pos_e, addr_e;
  logic [EW-1:0]      cur_e, len_e;
  gbl_pkg::status_t   status;
  logic [7:0]         char_rd;

  assign in_stall  = (state_r != gbl_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign left_e   = EW'(left_r);
  assign right_e  = EW'(right_r);
  assign total_e  = left_e + right_e;
  assign in_pos_e = EW'(in_data.position);
  assign pos_e    = EW'(cmd_r.position);

  // Read address for the command being taken; the data comes back next cycle.
  always_comb begin
    case (gbl_pkg::op_t'(in_data.opcode))
      gbl_pkg::OP_LEFT:  addr_e = left_e - EW'(1);
      gbl_pkg::OP_RIGHT: addr_e = CAP_E - right_e;
      default: begin
        if (in_pos_e < left_e) begin
          addr_e = in_pos_e;
        end else begin
          addr_e = in_pos_e + CAP_E - total_e;
        end
      end
    endcase
  end

  assign rd_en   = accept;
  assign rd_addr = addr_e[AW-1:0];

  // Next state.
  always_comb begin
    case (state_r)
      gbl_pkg::S_IDLE: state_nxt = accept ? gbl_pkg::S_EXEC : gbl_pkg::S_IDLE;
      gbl_pkg::S_EXEC: state_nxt = gbl_pkg::S_IDLE;
      default:         state_nxt = gbl_pkg::S_IDLE;
    endcase
  end

  // Execution of the held command.
  always_comb begin
    left_nxt      = left_r;
    right_nxt     = right_r;
    wr_en         = 1'b0;
    wr_addr       = left_r[AW-1:0];
    wr_data       = rd_data;
    status        = gbl_pkg::ST_DONE;
    char_rd       = 8'd0;
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == gbl_pkg::S_EXEC) begin
      out_valid_nxt = 1'b1;
      case (gbl_pkg::op_t'(cmd_r.opcode))
        gbl_pkg::OP_LEFT: begin
          if (left_r == '0) begin
            status = gbl_pkg::ST_EDGE;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = AW'(CAP_E - right_e - EW'(1));
            left_nxt  = left_r - CW'(1);
            right_nxt = right_r + CW'(1);
          end
        end
        gbl_pkg::OP_RIGHT: begin
          if (right_r == '0) begin
            status = gbl_pkg::ST_EDGE;
          end else begin
            wr_en     = 1'b1;
            left_nxt  = left_r + CW'(1);
            right_nxt = right_r - CW'(1);
          end
        end
        gbl_pkg::OP_BACK: begin
          if (left_r == '0) begin
            status = gbl_pkg::ST_EDGE;
          end else begin
            left_nxt = left_r - CW'(1);
          end
        end
        gbl_pkg::OP_INSERT: begin
          if (total_e >= CAP_E) begin
            status = gbl_pkg::ST_FULL;
          end else begin
            wr_en    = 1'b1;
            wr_data  = cmd_r.char_in;
            left_nxt = left_r + CW'(1);
          end
        end
        gbl_pkg::OP_READ: begin
          if (pos_e >= total_e) begin
            status = gbl_pkg::ST_RANGE;
          end else begin
            char_rd = rd_data;
          end
        end
        default: begin
          status = gbl_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign cur_e = EW'(left_nxt);
  assign len_e = EW'(left_nxt) + EW'(right_nxt);

  always_comb begin
    out_data_nxt = out_data_r;
    if (state_r == gbl_pkg::S_EXEC) begin
      out_data_nxt.status   = status;
      out_data_nxt.char_out = char_rd;
      out_data_nxt.cursor   = cur_e[gbl_pkg::COUNT_OUT_W-1:0];
      out_data_nxt.length   = len_e[gbl_pkg::COUNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbl_pkg::S_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hdl/gap_buffer_line_editor.sv
// ----------------------------------------------------------------------------
// gap_buffer_line_editor
// Line edit buffer with a cursor, kept as a gap buffer in one text store.
//
//   Channel   Ports                            Direction
//   input     in_valid, in_stall, in_data      command word in
//   output    out_valid, out_stall, out_data   result word out
//
// A word is not taken while the command before it executes. The store read is
// issued when the word is taken; the write back follows in the next cycle,
// set by the single registered store read port; the result is registered.
// Reset clears the cursor and length; the store itself is not cleared.
// A new word is taken while a result waits only if that result leaves in
// the same cycle; a stalled result holds the input off.
// ----------------------------------------------------------------------------
module gap_buffer_line_editor #(
  parameter int unsigned CAPACITY = gbl_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gbl_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gbl_pkg::out_word_t out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  gbl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  gbl_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

>>> tb/tb_gap_buffer_line_editor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_line_editor
// Self-checking bench for the gap buffer line editor. Edit commands are
// applied through the input channel. A behavioral copy of the line, the
// cursor and the length predicts each result word, and a checker compares
// every returned word field by field. Directed edge cases come first, then
// random editing under changing idle and stall rates, a long output stall,
// and a fill of the whole store.
// ----------------------------------------------------------------------------
module tb_gap_buffer_line_editor;

  localparam int unsigned CAPACITY    = gbl_pkg::CAPACITY_DEF;
  localparam int unsigned OP_MAX_CODE = 7;
  localparam int unsigned POS_MAX     = (1 << gbl_pkg::POS_W) - 1;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  gbl_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  gbl_pkg::out_word_t out_data;

  // Behavioral copy of the line.
  logic [7:0]  line_mem [CAPACITY];
  int unsigned n_left  = 0;
  int unsigned n_right = 0;

  gbl_pkg::out_word_t results_pending[$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_cycles   = 0;

  gap_buffer_line_editor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one command to the line copy and returns the word it should give.
  function automatic gbl_pkg::out_word_t predict_edit(gbl_pkg::in_word_t w);
    gbl_pkg::out_word_t r;
    int unsigned        total;
    total = n_left + n_right;
    r = '0;
    r.status = gbl_pkg::ST_DONE;
    case (w.opcode)
      gbl_pkg::OP_LEFT: begin
        if (n_left == 0) begin
          r.status = gbl_pkg::ST_EDGE;
        end else begin
          line_mem[CAPACITY - n_right - 1] = line_mem[n_left - 1];
          n_left--;
          n_right++;
        end
      end
      gbl_pkg::OP_RIGHT: begin
        if (n_right == 0) begin
          r.status = gbl_pkg::ST_EDGE;
        end else begin
          line_mem[n_left] = line_mem[CAPACITY - n_right];
          n_left++;
          n_right--;
        end
      end
      gbl_pkg::OP_BACK: begin
        if (n_left == 0) r.status = gbl_pkg::ST_EDGE;
        else n_left--;
      end
      gbl_pkg::OP_INSERT: begin
        if (total >= CAPACITY) begin
          r.status = gbl_pkg::ST_FULL;
        end else begin
          line_mem[n_left] = w.char_in;
          n_left++;
        end
      end
      gbl_pkg::OP_READ: begin
        if (w.position >= total) r.status = gbl_pkg::ST_RANGE;
        else if (w.position < n_left) r.char_out = line_mem[w.position];
        else r.char_out = line_mem[CAPACITY - n_right + (w.position - n_left)];
      end
      default: ;
    endcase
    r.cursor = gbl_pkg::COUNT_OUT_W'(n_left);
    r.length = gbl_pkg::COUNT_OUT_W'(n_left + n_right);
    return r;
  endfunction

  function automatic gbl_pkg::in_word_t make_cmd(logic [2:0] op, logic [7:0] ch,
                                                 logic [gbl_pkg::POS_W-1:0] pos);
    gbl_pkg::in_word_t w;
    w.opcode   = op;
    w.char_in  = ch;
    w.position = pos;
    return w;
  endfunction

  // Mostly sensible edits; reads usually land inside the text.
  function automatic gbl_pkg::in_word_t pick_edit_command();
    int unsigned               r;
    int unsigned               total;
    logic [2:0]                op;
    logic [gbl_pkg::POS_W-1:0] pos;
    r     = $urandom_range(99);
    total = n_left + n_right;
    pos   = gbl_pkg::POS_W'($urandom_range(POS_MAX));
    if (r < 15)      op = gbl_pkg::OP_LEFT;
    else if (r < 30) op = gbl_pkg::OP_RIGHT;
    else if (r < 42) op = gbl_pkg::OP_BACK;
    else if (r < 64) op = gbl_pkg::OP_INSERT;
    else if (r < 94) op = gbl_pkg::OP_READ;
    else             op = 3'($urandom_range(gbl_pkg::OP_READ + 1, OP_MAX_CODE));
    if (op == gbl_pkg::OP_READ && total > 0 && $urandom_range(99) < 80)
      pos = gbl_pkg::POS_W'($urandom_range(total - 1));
    return make_cmd(op, 8'($urandom_range(255)), pos);
  endfunction

  // Offers one word and returns at the clock edge where it is taken.
  task automatic send_word(input gbl_pkg::in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    results_pending.push_back(predict_edit(w));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_line_edges();
    send_word(make_cmd(gbl_pkg::OP_LEFT, 8'hFF, gbl_pkg::POS_W'(POS_MAX)));
    send_word(make_cmd(gbl_pkg::OP_RIGHT, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_BACK, 8'hFF, '0));
    send_word(make_cmd(gbl_pkg::OP_READ, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_READ, 8'hFF, gbl_pkg::POS_W'(POS_MAX)));
    for (int unsigned op = gbl_pkg::OP_READ + 1; op <= OP_MAX_CODE; op++)
      send_word(make_cmd(3'(op), 8'hFF, gbl_pkg::POS_W'(POS_MAX)));
  endtask

  task automatic test_basic_editing();
    send_word(make_cmd(gbl_pkg::OP_INSERT, 8'h00, gbl_pkg::POS_W'(POS_MAX)));
    send_word(make_cmd(gbl_pkg::OP_INSERT, 8'hFF, '0));
    send_word(make_cmd(gbl_pkg::OP_INSERT, 8'hA5, '0));
    send_word(make_cmd(gbl_pkg::OP_INSERT, 8'h5A, '0));
    // The first move left fills the very top entry of the store.
    send_word(make_cmd(gbl_pkg::OP_LEFT, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_LEFT, 8'h00, '0));
    for (int unsigned p = 0; p <= 4; p++)
      send_word(make_cmd(gbl_pkg::OP_READ, 8'h00, gbl_pkg::POS_W'(p)));
    send_word(make_cmd(gbl_pkg::OP_RIGHT, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_RIGHT, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_RIGHT, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_BACK, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_INSERT, 8'h81, '0));
    send_word(make_cmd(gbl_pkg::OP_READ, 8'h00, gbl_pkg::POS_W'(POS_MAX)));
  endtask

  task automatic test_random_editing(input int unsigned count);
    repeat (count) send_word(pick_edit_command());
  endtask

  // The output stalls for a long stretch while words keep coming, so the
  // block backs up; then the sender waits for every result.
  task automatic test_backpressure();
    int unsigned saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_cycles   = 80;
    repeat (12) send_word(pick_edit_command());
    wait_for_results();
    send_idle_pct = saved_idle;
  endtask

  task automatic test_fill_to_capacity();
    int unsigned room;
    room = CAPACITY - (n_left + n_right);
    repeat (room) send_word(make_cmd(gbl_pkg::OP_INSERT, 8'($urandom_range(255)),
                                     gbl_pkg::POS_W'($urandom_range(POS_MAX))));
    send_word(make_cmd(gbl_pkg::OP_INSERT, 8'h3C, '0));
    send_word(make_cmd(gbl_pkg::OP_READ, 8'h00, gbl_pkg::POS_W'(POS_MAX)));
    send_word(make_cmd(gbl_pkg::OP_READ, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_LEFT, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_READ, 8'h00, gbl_pkg::POS_W'(POS_MAX)));
    send_word(make_cmd(gbl_pkg::OP_RIGHT, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_RIGHT, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_BACK, 8'h00, '0));
    send_word(make_cmd(gbl_pkg::OP_INSERT, 8'hC3, '0));
    send_word(make_cmd(gbl_pkg::OP_INSERT, 8'h99, '0));
    repeat (40) send_word(pick_edit_command());
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    gbl_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        mismatches++;
      end else begin
        want = results_pending.pop_front();
        report_field("status", want.status, out_data.status);
        report_field("char_out", want.char_out, out_data.char_out);
        report_field("cursor", want.cursor, out_data.cursor);
        report_field("length", want.length, out_data.length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    stall_pct     = 77;
    test_empty_line_edges();
    test_basic_editing();
    test_random_editing(120);

    send_idle_pct = 77;
    stall_pct     = 20;
    test_random_editing(100);
    test_backpressure();

    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_editing(100);
    test_fill_to_capacity();

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && results_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/gbl_pkg.sv
hdl/gbl_store.sv
hdl/gbl_ctrl.sv
hdl/gap_buffer_line_editor.sv
tb/tb_gap_buffer_line_editor.sv
